// ===== sv/slins_pkg.sv =====
// package for the sorted insertion list
// beat types, command codes and sizing constants; no dependencies
package slins_pkg;

  localparam int unsigned Capacity = 32;
  localparam int unsigned AddrW    = (Capacity > 1) ? $clog2(Capacity) : 1;
  localparam int unsigned CntW     = $clog2(Capacity + 1);
  localparam int unsigned ValW     = 32;
  localparam int unsigned PosW     = 5;

  localparam logic [1:0] CmdInsert     = 2'd0;
  localparam logic [1:0] CmdDump       = 2'd1;
  localparam logic [1:0] CmdInsertDump = 2'd2;

  typedef struct packed {
    logic [1:0]             cmd;
    logic signed [ValW-1:0] value;
  } in_t;

  typedef struct packed {
    logic signed [ValW-1:0] entry_value;
    logic [PosW-1:0]        position;
    logic                   last;
    logic                   rejected;
  } out_t;

endpackage

// ===== sv/slins_ram.sv =====
// generic single-port-write, single-port-read ram with registered read data
// no dependencies
module slins_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 32
) (
  input  logic                                    clk_i,
  input  logic                                    wr_en_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] wr_addr_i,
  input  logic [Width-1:0]                        wr_data_i,
  input  logic                                    rd_en_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] rd_addr_i,
  output logic [Width-1:0]                        rd_data_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// ===== sv/sorted_list_insert.sv =====
// top level of the sorted insertion list: sequencer, compare unit, output register
// depends on slins_pkg and slins_ram
//
// channel  direction  handshake                  beat type
// in       input      in_valid_i / in_ready_o    in_t  (cmd, value)
// out      output     out_valid_o / out_ready_i  out_t (entry_value, position, last, rejected)
//
// an insert walks down from the top entry through one ram port and one signed compare,
// each step reading an entry (StInsRd), then writing it up one slot or writing the value (StInsCmp);
// when the value lands at position zero it is written there without a read
// a dump reads each entry from the ram, then loads it into the output register (StDumpRd, StDumpOut),
// and waits while out stalls; it ends when the index reaches the entry count
// in_ready_o is high only in idle; a result may still wait in the output register then
// reset clears the entry count and the sequencer; ram contents are never cleared
// a rejected insert costs one result beat and leaves the list unchanged
module sorted_list_insert
  import slins_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  in_t  in_data_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output out_t out_data_o
);

  // sequencer states
  localparam logic [2:0] StIdle    = 3'd0;
  localparam logic [2:0] StInsRd   = 3'd1;
  localparam logic [2:0] StInsCmp  = 3'd2;
  localparam logic [2:0] StDumpRd  = 3'd3;
  localparam logic [2:0] StDumpOut = 3'd4;
  localparam logic [2:0] StRej     = 3'd5;

  logic [2:0]             state_q, state_d;
  logic [CntW-1:0]        count_q, count_d;
  logic [CntW-1:0]        idx_q, idx_d;
  logic signed [ValW-1:0] value_q, value_d;
  logic                   dump_after_q, dump_after_d;

  logic                   out_valid_q;
  out_t                   out_data_q;
  out_t                   out_next;
  logic                   out_load;
  logic                   out_free;

  // ram port controls
  logic                   wr_en;
  logic [AddrW-1:0]       wr_addr;
  logic [ValW-1:0]        wr_data;
  logic                   rd_en;
  logic [AddrW-1:0]       rd_addr;
  logic [ValW-1:0]        rd_data;

  // the one shared compare: stored entry against the value being inserted
  logic                   entry_not_smaller;

  slins_ram #(
    .Width (ValW),
    .Depth (Capacity)
  ) u_store (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  assign entry_not_smaller = $signed(rd_data) >= value_q;
  // output register can take a beat when empty or being drained this cycle
  assign out_free          = !out_valid_q || out_ready_i;
  assign in_ready_o        = (state_q == StIdle);

  always_comb begin
    state_d      = state_q;
    count_d      = count_q;
    idx_d        = idx_q;
    value_d      = value_q;
    dump_after_d = dump_after_q;
    wr_en        = 1'b0;
    wr_addr      = '0;
    wr_data      = value_q;
    rd_en        = 1'b0;
    rd_addr      = '0;
    out_load     = 1'b0;
    out_next     = '0;

    unique case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          value_d = in_data_i.value;
          unique case (in_data_i.cmd) inside
            CmdInsert, CmdInsertDump: begin
              dump_after_d = (in_data_i.cmd == CmdInsertDump);
              idx_d        = count_q;
              state_d      = (count_q == CntW'(Capacity)) ? StRej : StInsRd;
            end
            CmdDump: begin
              dump_after_d = 1'b0;
              idx_d        = '0;
              state_d      = StDumpRd;
            end
            default: begin
              // unused code: no result, no change
              state_d = StIdle;
            end
          endcase
        end
      end

      StRej: begin
        if (out_free) begin
          out_load             = 1'b1;
          out_next.entry_value = value_q;
          out_next.position    = '0;
          out_next.last        = 1'b1;
          out_next.rejected    = 1'b1;
          state_d              = StIdle;
        end
      end

      StInsRd: begin
        if (idx_q == '0) begin
          // walked past the bottom: value lands at position zero
          wr_en   = 1'b1;
          wr_addr = '0;
          wr_data = value_q;
          count_d = count_q + 1'b1;
          idx_d   = '0;
          state_d = dump_after_q ? StDumpRd : StIdle;
        end else begin
          rd_en   = 1'b1;
          rd_addr = AddrW'(idx_q - 1'b1);
          state_d = StInsCmp;
        end
      end

      StInsCmp: begin
        wr_en   = 1'b1;
        wr_addr = AddrW'(idx_q);
        if (entry_not_smaller) begin
          // move the entry up one slot and keep walking down
          wr_data = rd_data;
          idx_d   = idx_q - 1'b1;
          state_d = StInsRd;
        end else begin
          wr_data = value_q;
          count_d = count_q + 1'b1;
          idx_d   = '0;
          state_d = dump_after_q ? StDumpRd : StIdle;
        end
      end

      StDumpRd: begin
        if (idx_q == count_q) begin
          state_d = StIdle;
        end else begin
          rd_en   = 1'b1;
          rd_addr = AddrW'(idx_q);
          state_d = StDumpOut;
        end
      end

      StDumpOut: begin
        // read data holds while no new read is issued
        if (out_free) begin
          out_load             = 1'b1;
          out_next.entry_value = $signed(rd_data);
          out_next.position    = PosW'(idx_q);
          out_next.last        = (CntW'(idx_q + 1'b1) == count_q);
          out_next.rejected    = 1'b0;
          idx_d                = idx_q + 1'b1;
          state_d              = StDumpRd;
        end
      end

      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      count_q     <= '0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      idx_q   <= idx_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk_i) begin
    value_q      <= value_d;
    dump_after_q <= dump_after_d;
    if (out_load) begin
      out_data_q <= out_next;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

`ifndef ASSERT_OFF
  a_count_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(Capacity))
    else $error("entry count above capacity");

  a_count_steps_by_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$stable(count_q) |-> (count_q == $past(count_q) + 1'b1))
    else $error("entry count changed by other than one");

  a_idx_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != StIdle) |-> (idx_q <= count_q))
    else $error("walk index beyond entry count");

  a_reject_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.rejected) |-> out_data_o.last)
    else $error("rejected beat not marked last");

  a_no_load_over_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_load && out_valid_q) |-> out_ready_i)
    else $error("output register overwritten while held");
`endif

endmodule
